// ----- hdl/dtnf_pkg.sv -----
// Shared types, constants and the power-of-ten table for the decimal text
// to nano fixed-point converter. No dependencies.
package dtnf_pkg;

  localparam int unsigned MagW   = 63;  // magnitude width in nanos
  localparam int unsigned IntW   = 32;  // integer accumulator width
  localparam int unsigned FracW  = 30;  // fraction accumulator width
  localparam int unsigned PowW   = 54;  // holds 10^16
  localparam int unsigned CntW   = 6;   // holds MagW

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [3:0] DigitMask = 4'hF;

  localparam logic [FracW-1:0] NanosPerUnit = 30'd1000000000;
  localparam logic [3:0]       FracDigits   = 4'd9;
  localparam logic [CntW-1:0]  DivSteps     = CntW'(MagW);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_INT   = 2'd1,
    PH_FRAC  = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_PARSE,
    S_MUL_INT,
    S_MUL_FRAC,
    S_SUM,
    S_UP,
    S_DIV,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take_char;
    logic last_char;
    logic mul_int;
    logic mul_frac;
    logic sum;
    logic up_step;
    logic dn_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scale_up;
    logic       scale_dn;
    logic [4:0] scale_k;
  } status_t;

  function automatic logic [PowW-1:0] pow10(input logic [4:0] k);
    logic [PowW-1:0] r;
    case (k)
      5'd0:    r = 54'd1;
      5'd1:    r = 54'd10;
      5'd2:    r = 54'd100;
      5'd3:    r = 54'd1000;
      5'd4:    r = 54'd10000;
      5'd5:    r = 54'd100000;
      5'd6:    r = 54'd1000000;
      5'd7:    r = 54'd10000000;
      5'd8:    r = 54'd100000000;
      5'd9:    r = 54'd1000000000;
      5'd10:   r = 54'd10000000000;
      5'd11:   r = 54'd100000000000;
      5'd12:   r = 54'd1000000000000;
      5'd13:   r = 54'd10000000000000;
      5'd14:   r = 54'd100000000000000;
      5'd15:   r = 54'd1000000000000000;
      5'd16:   r = 54'd10000000000000000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/dtnf_intf.sv -----
// Valid/ready channel interfaces for the character input and the result
// output. Depends on nothing.
interface dtnf_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        character;
  logic              final_char;
  logic signed [4:0] decimal_order;

  modport source (output valid, character, final_char, decimal_order, input ready);
  modport sink   (input valid, character, final_char, decimal_order, output ready);
endinterface

interface dtnf_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] magnitude_nanos;
  logic        is_negative;

  modport source (output valid, magnitude_nanos, is_negative, input ready);
  modport sink   (input valid, magnitude_nanos, is_negative, output ready);
endinterface

// ----- hdl/dtnf_dp.sv -----
// Datapath: character parser, shared 32x30 multiplier, x10 scaler and a
// restoring divider by 10^k. Depends on dtnf_pkg.
module dtnf_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtnf_pkg::cmd_t    cmd_i,
  output dtnf_pkg::status_t status_o,
  input  logic [7:0]        character_i,
  input  logic [4:0]        decimal_order_i,
  output logic [62:0]       magnitude_nanos_o,
  output logic              is_negative_o
);
  import dtnf_pkg::*;

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [IntW-1:0]   int_q, int_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [4:0]        ord_q;
  logic              sign_q;
  logic [61:0]       prod_q;
  logic [MagW-1:0]   acc_q;
  logic [PowW-1:0]   rem_q;
  logic [PowW-1:0]   div_q;
  logic [PowW-1:0]   pw_full;
  logic [IntW-1:0]   mul_a;
  logic [FracW-1:0]  mul_b;
  logic              is_dig;
  logic [3:0]        dig;
  logic [PowW:0]     trial;
  logic              ge;

  assign dig    = character_i[3:0] & DigitMask;
  assign is_dig = (character_i >= CharZero) && (character_i <= CharNine);

  // parser
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    if (cmd_i.mul_frac) begin
      // last reader of the parse state: start a new string
      phase_d = PH_START;
      neg_d   = 1'b0;
      int_d   = '0;
      frac_d  = '0;
      cnt_d   = '0;
    end else if (cmd_i.take_char) begin
      unique case (phase_q)
        PH_START: begin
          if (character_i == CharPlus) begin
            phase_d = PH_INT;
          end else if (character_i == CharMinus) begin
            neg_d   = 1'b1;
            phase_d = PH_INT;
          end else if (is_dig) begin
            int_d   = {28'd0, dig};
            phase_d = PH_INT;
          end else if (character_i == CharDot) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_INT: begin
          if (is_dig) begin
            int_d = int_q * 32'd10 + {28'd0, dig};
          end else if (character_i == CharDot) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_FRAC: begin
          if (is_dig) begin
            if (cnt_q < FracDigits) begin
              frac_d = frac_q * 30'd10 + {26'd0, dig};
              cnt_d  = cnt_q + 4'd1;
            end
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_STOP: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
    end
  end

  // shared multiplier: integer part, then zero-padded fraction
  assign pw_full = pow10({1'b0, FracDigits - cnt_q});
  assign mul_a   = cmd_i.mul_frac ? {2'd0, frac_q} : int_q;
  assign mul_b   = cmd_i.mul_frac ? pw_full[FracW-1:0] : NanosPerUnit;

  assign status_o.scale_dn = ord_q[4];
  assign status_o.scale_up = !ord_q[4] && (ord_q != 5'd0);
  assign status_o.scale_k  = ord_q[4] ? (5'd0 - ord_q) : ord_q;

  assign trial = {rem_q, acc_q[MagW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.last_char) begin
      ord_q <= decimal_order_i;
    end
    if (cmd_i.mul_frac) begin
      acc_q  <= {1'b0, prod_q};
      sign_q <= neg_q;
    end
    if (cmd_i.sum) begin
      acc_q <= acc_q + {1'b0, prod_q};
      rem_q <= '0;
      div_q <= pow10(status_o.scale_k);
    end
    if (cmd_i.up_step) begin
      acc_q <= (acc_q << 3) + (acc_q << 1);
    end
    if (cmd_i.dn_step) begin
      // shift one dividend bit in, subtract when it fits
      acc_q <= {acc_q[MagW-2:0], ge};
      rem_q <= ge ? trial[PowW-1:0] - div_q : trial[PowW-1:0];
    end
    if (cmd_i.load_out) begin
      magnitude_nanos_o <= acc_q;
      is_negative_o     <= sign_q;
    end
  end

endmodule

// ----- hdl/dtnf_ctrl.sv -----
// Controller: sequences parse, multiply, scale and output load, and owns the
// input ready and output valid. Depends on dtnf_pkg.
module dtnf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              final_char_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dtnf_pkg::status_t status_i,
  output dtnf_pkg::cmd_t    cmd_o
);
  import dtnf_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            can_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_PARSE:    if (in_valid_i && final_char_i) state_d = S_MUL_INT;
      S_MUL_INT:  state_d = S_MUL_FRAC;
      S_MUL_FRAC: state_d = S_SUM;
      S_SUM: begin
        if (status_i.scale_up) begin
          state_d = S_UP;
        end else if (status_i.scale_dn) begin
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP, S_DIV: if (cnt_q == CntW'(1)) state_d = S_DONE;
      S_DONE:     if (can_load) state_d = S_PARSE;
      default:    state_d = S_PARSE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    cnt_d           = cnt_q;
    unique case (state_q)
      S_PARSE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_char = in_valid_i;
        cmd_o.last_char = in_valid_i && final_char_i;
      end
      S_MUL_INT:  cmd_o.mul_int  = 1'b1;
      S_MUL_FRAC: cmd_o.mul_frac = 1'b1;
      S_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_d     = status_i.scale_up ? {1'b0, status_i.scale_k} : DivSteps;
      end
      S_UP: begin
        cmd_o.up_step = 1'b1;
        cnt_d         = cnt_q - CntW'(1);
      end
      S_DIV: begin
        cmd_o.dn_step = 1'b1;
        cnt_d         = cnt_q - CntW'(1);
      end
      S_DONE:  cmd_o.load_out = can_load;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PARSE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while waiting");

  a_final_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && final_char_i) |=> (state_q == S_MUL_INT))
    else $error("final character did not start the calculation");

  a_scale_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP || state_q == S_DIV) |-> (cnt_q != '0))
    else $error("scale step counter ran out");

  a_load_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

// ----- hdl/decimal_text_to_nano_fixed.sv -----
// Top level of the decimal text to nano fixed-point converter.
// Depends on dtnf_pkg, dtnf_intf, dtnf_ctrl and dtnf_dp.
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    character, final_char, decimal_order
//  out_o    out  valid/ready    magnitude_nanos, is_negative
//
// A character that is not final only updates the parser.
// A final character runs the multiply and sum states, then one x10 step per
// unit of a positive order or the 63-step restoring divider by 10^k for a
// negative order, and then the output load.
// Reset clears the parser and controller; no clearing pass.
// A result waits in the output register; parsing goes on meanwhile. Input is
// held during each calculation and until the next result can be loaded.
module decimal_text_to_nano_fixed (
  input logic   clk_i,
  input logic   rst_ni,
  dtnf_in_if.sink    in_i,
  dtnf_out_if.source out_o
);
  import dtnf_pkg::*;

  cmd_t    cmd;
  status_t status;

  dtnf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .final_char_i (in_i.final_char),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  dtnf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .character_i       (in_i.character),
    .decimal_order_i   (in_i.decimal_order),
    .magnitude_nanos_o (out_o.magnitude_nanos),
    .is_negative_o     (out_o.is_negative)
  );

endmodule

// ----- bench/dtnf_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for decimal_text_to_nano_fixed: watches both channels, parses
// the accepted text on its own and compares every result transfer.
// Depends on dtnf_pkg and the channel interfaces in dtnf_intf.
module dtnf_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dtnf_in_if   in_i,
  dtnf_out_if  out_i,
  output int   fail_count_o,
  output int   pending_o
);
  import dtnf_pkg::*;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic            negative;
  } nano_result_t;

  nano_result_t     expected_nanos[$];
  nano_result_t     want;
  phase_e           phase_q;
  logic             neg_q;
  logic [IntW-1:0]  int_acc;
  logic [FracW-1:0] frac_acc;
  logic [3:0]       frac_digits;
  int               mismatches;

  function automatic logic [63:0] ten_to(input int unsigned k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return p;
  endfunction

  task automatic clear_parse();
    phase_q     = PH_START;
    neg_q       = 1'b0;
    int_acc     = '0;
    frac_acc    = '0;
    frac_digits = '0;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CharZero) && (c <= CharNine);
    case (phase_q)
      PH_START: begin
        if (c == CharPlus) begin
          phase_q = PH_INT;
        end else if (c == CharMinus) begin
          neg_q   = 1'b1;
          phase_q = PH_INT;
        end else if (is_digit) begin
          int_acc = IntW'(c[3:0]);
          phase_q = PH_INT;
        end else if (c == CharDot) begin
          phase_q = PH_FRAC;
        end else begin
          phase_q = PH_STOP;
        end
      end
      PH_INT: begin
        // integer part wraps modulo 2^32, however long it gets
        if (is_digit) begin
          int_acc = int_acc * 32'd10 + IntW'(c[3:0]);
        end else if (c == CharDot) begin
          phase_q = PH_FRAC;
        end else begin
          phase_q = PH_STOP;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          // drop fraction digits past the ninth
          if (frac_digits < FracDigits) begin
            frac_acc    = frac_acc * 30'd10 + FracW'(c[3:0]);
            frac_digits = frac_digits + 4'd1;
          end
        end else begin
          phase_q = PH_STOP;
        end
      end
      default: ;
    endcase
  endtask

  function automatic nano_result_t scaled_nanos(input logic signed [4:0] order);
    logic [63:0]  nanos;
    int           ord;
    nano_result_t r;
    ord   = order;
    nanos = 64'(int_acc) * 64'(NanosPerUnit) + 64'(frac_acc) * ten_to(9 - frac_digits);
    if (ord < 0) begin
      nanos = nanos / ten_to(-ord);
    end else if (ord > 0) begin
      nanos = nanos * ten_to(ord);
    end
    r.magnitude = nanos[MagW-1:0];
    r.negative  = neg_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      expected_nanos.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        parse_char(in_i.character);
        if (in_i.final_char) begin
          expected_nanos.push_back(scaled_nanos(in_i.decimal_order));
          clear_parse();
        end
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_nanos.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result nanos=%0d neg=%0b", $time,
                     out_i.magnitude_nanos, out_i.is_negative);
        end else begin
          want = expected_nanos.pop_front();
          if (out_i.magnitude_nanos !== want.magnitude ||
              out_i.is_negative !== want.negative) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch nanos exp=%0d got=%0d, neg exp=%0b got=%0b", $time,
                       want.magnitude, out_i.magnitude_nanos, want.negative,
                       out_i.is_negative);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_nanos.size();
    end
  end

endmodule

// ----- bench/decimal_text_to_nano_fixed_tb.sv -----
`timescale 1ns / 1ps
// Top of the decimal_text_to_nano_fixed bench: clock, reset, character
// stimulus, output stalls, watchdog and verdict.
// Depends on dtnf_pkg, dtnf_intf, the converter and dtnf_result_checker.
module decimal_text_to_nano_fixed_tb;
  import dtnf_pkg::*;

  localparam int TargetChars  = 600;
  localparam int StallLimit   = 4000;
  localparam int SettleCycles = 100;

  typedef enum int {RX_FREE, RX_RANDOM, RX_THIRD, RX_SPARSE} rx_mode_e;

  logic       clk_i  = 1'b0;
  logic       rst_ni;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         burst_left  = 0;
  rx_mode_e   rx_mode     = RX_FREE;
  int         rx_age      = 0;
  logic [7:0] text_q[$];

  dtnf_in_if  in_w ();
  dtnf_out_if out_w ();

  decimal_text_to_nano_fixed u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  dtnf_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_w),
    .out_i        (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // receiver stalls: switch between a few patterns every so often
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_w.ready <= 1'b0;
    end else begin
      if (rx_age == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_age  = $urandom_range(50, 250);
      end
      rx_age--;
      case (rx_mode)
        RX_FREE:   out_w.ready <= 1'b1;
        RX_RANDOM: out_w.ready <= ($urandom_range(0, 3) != 0);
        RX_THIRD:  out_w.ready <= (rx_age % 3 == 0);
        default:   out_w.ready <= (rx_age % 32 < 6);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // send text_q as one string; the last character carries the order
  task automatic send_text(input logic signed [4:0] order);
    int gap;
    for (int i = 0; i < text_q.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 12);
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_w.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      in_w.valid      <= 1'b1;
      in_w.character  <= text_q[i];
      in_w.final_char <= (i == text_q.size() - 1);
      in_w.decimal_order <= (i == text_q.size() - 1) ? order : 5'($urandom);
      do @(posedge clk_i); while (!in_w.ready);
      burst_left--;
    end
  endtask

  task automatic send_literal(input string s, input logic signed [4:0] order);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text(order);
  endtask

  // hold off until every result is back
  task automatic drain();
    in_w.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // number: optional sign, zero or more integer digits, optional fraction
  task automatic build_number();
    int n_int;
    int n_frac;
    text_q.delete();
    case ($urandom_range(0, 2))
      1:       text_q.push_back(CharPlus);
      2:       text_q.push_back(CharMinus);
      default: ;
    endcase
    n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    repeat (n_int) text_q.push_back(CharZero + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 2) != 0) begin
      text_q.push_back(CharDot);
      n_frac = $urandom_range(0, 12);
      repeat (n_frac) text_q.push_back(CharZero + 8'($urandom_range(0, 9)));
    end
    if (text_q.size() == 0) text_q.push_back(CharZero + 8'($urandom_range(0, 9)));
  endtask

  initial begin
    int               sent;
    int               strings;
    int               kind;
    logic [7:0]       junk;
    logic signed [4:0] order;
    sent    = 0;
    strings = 0;
    rst_ni             <= 1'b0;
    in_w.valid         <= 1'b0;
    in_w.character     <= '0;
    in_w.final_char    <= 1'b0;
    in_w.decimal_order <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone minus, dot then sign, stray byte at the most negative order,
    // sign after a digit, ten fraction digits, wrapping integer at max order
    send_literal("-", 5'sd0);
    send_literal(".+", 5'sd9);
    text_q.delete();
    text_q.push_back(8'hFF);
    send_text(-5'sd16);
    send_literal("7+", 5'sd1);
    send_literal("-.1234567891", -5'sd3);
    send_literal("9999999999", 5'sd15);
    drain();

    while (sent < TargetChars) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // pure noise
        text_q.delete();
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_number();
        if (kind >= 7) begin
          junk = ($urandom_range(0, 1) == 0) ? (($urandom_range(0, 1) == 0) ? CharPlus
                                                                            : CharMinus)
                                             : 8'($urandom_range(0, 255));
          text_q.insert($urandom_range(0, text_q.size()), junk);
          if (kind == 8)
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      sent += text_q.size();
      order = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, 18) - 9);
      send_text(order);
      strings++;
      if (strings % 25 == 0) drain();
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
